// ===== rtl/mrg_pkg.sv =====
package mrg_pkg;

  // default sizes
  localparam int MAX_ROWS_DEF  = 8;
  localparam int MAX_COLS_DEF  = 8;
  localparam int FRAC_BITS_DEF = 16;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_ROWS = 2'd0,
    CFG_COLS = 2'd1,
    CFG_TOL  = 2'd2
  } cfg_idx_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_COPY_RD,
    S_COPY_WR,
    S_COL,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_SW_RD,
    S_SW_WA,
    S_SW_WB,
    S_EL_ROW,
    S_EL_CHK,
    S_EL_DIV,
    S_EL_RD,
    S_EL_MUL,
    S_EL_WR,
    S_FIN
  } state_t;

  // work memory write source
  typedef enum logic [2:0] {
    WS_STORE,
    WS_A,
    WS_B,
    WS_UPD,
    WS_ZERO
  } wsel_t;

  typedef struct packed {
    logic  copy_rd;
    logic  rd_en;
    logic  wr_en;
    wsel_t wr_sel;
    logic  div_start;
    logic  mul_en;
    logic  sat_clr;
  } cmd_t;

  typedef struct packed {
    logic over_tol;
    logic a_zero;
    logic div_busy;
    logic sat;
  } sts_t;

  // magnitude of a signed 32-bit value, exact for the most negative value
  function automatic logic [31:0] abs32(input logic [31:0] v);
    abs32 = v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

// ===== rtl/mrg_dp.sv =====
module mrg_dp #(
  parameter int MAX_ROWS  = mrg_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS  = mrg_pkg::MAX_COLS_DEF,
  parameter int FRAC_BITS = mrg_pkg::FRAC_BITS_DEF,
  parameter int RW = $clog2(MAX_ROWS + 1),
  parameter int CW = $clog2(MAX_COLS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load_en,
  input  logic [2:0]    load_row,
  input  logic [2:0]    load_col,
  input  logic [31:0]   load_val,
  input  logic [30:0]   tol,
  input  mrg_pkg::cmd_t cmd,
  input  logic [RW-1:0] a_row,
  input  logic [CW-1:0] a_col,
  input  logic [RW-1:0] b_row,
  input  logic [CW-1:0] b_col,
  input  logic [RW-1:0] w_row,
  input  logic [CW-1:0] w_col,
  output mrg_pkg::sts_t sts
);
  import mrg_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = 32 + FRAC_BITS;
  localparam int NW    = $clog2(DW + 1);

  logic [31:0] store_mem [DEPTH];
  logic [31:0] work_mem  [DEPTH];

  logic [31:0] store_q_r;
  logic [31:0] rd_a_r;
  logic [31:0] rd_b_r;
  logic [AW-1:0] addr_a, addr_b, addr_w, addr_ld;
  logic          ld_ok;

  // linear addresses
  assign addr_a  = AW'(32'(a_row) * MAX_COLS + 32'(a_col));
  assign addr_b  = AW'(32'(b_row) * MAX_COLS + 32'(b_col));
  assign addr_w  = AW'(32'(w_row) * MAX_COLS + 32'(w_col));
  assign addr_ld = AW'(32'(load_row) * MAX_COLS + 32'(load_col));
  assign ld_ok   = (32'(load_row) < MAX_ROWS) && (32'(load_col) < MAX_COLS);

  // element store, loaded one transfer at a time
  always_ff @(posedge clk) begin
    if (load_en && ld_ok) begin
      store_mem[addr_ld] <= load_val;
    end
    if (cmd.copy_rd) begin
      store_q_r <= store_mem[addr_a];
    end
  end

  // divider state
  logic [DW-1:0] dvd_r, dvd_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [32:0]   rem_r, rem_nxt;
  logic [31:0]   den_r;
  logic          neg_r;
  logic [NW-1:0] cnt_r;
  logic          busy_r;
  logic [31:0]   f_r;
  logic [31:0]   f_nxt;
  logic          f_sat;
  logic [32:0]   rem_sh;

  // one restoring step per cycle
  always_comb begin
    rem_sh  = {rem_r[31:0], dvd_r[DW-1]};
    dvd_nxt = {dvd_r[DW-2:0], 1'b0};
    if (rem_sh >= {1'b0, den_r}) begin
      rem_nxt = rem_sh - {1'b0, den_r};
      quo_nxt = {quo_r[DW-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh;
      quo_nxt = {quo_r[DW-2:0], 1'b0};
    end
  end

  // signed factor with saturation
  always_comb begin
    f_sat = 1'b0;
    if (!neg_r && (quo_nxt > DW'(32'h7fffffff))) begin
      f_nxt = 32'h7fffffff;
      f_sat = 1'b1;
    end else if (neg_r && (quo_nxt > DW'(33'h080000000))) begin
      f_nxt = 32'h80000000;
      f_sat = 1'b1;
    end else if (neg_r) begin
      f_nxt = ~quo_nxt[31:0] + 32'd1;
    end else begin
      f_nxt = quo_nxt[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (cmd.div_start) begin
      busy_r <= 1'b1;
      cnt_r  <= NW'(DW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - NW'(1);
      if (cnt_r == NW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd_r <= DW'(abs32(rd_a_r)) << FRAC_BITS;
      den_r <= abs32(rd_b_r);
      neg_r <= rd_a_r[31] ^ rd_b_r[31];
      quo_r <= '0;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      if (cnt_r == NW'(1)) begin
        f_r <= f_nxt;
      end
    end
  end

  // product stage
  logic signed [63:0] prod_r;
  logic signed [63:0] shifted, diff;
  logic [31:0]        upd;
  logic               upd_sat;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= $signed(f_r) * $signed(rd_b_r);
    end
  end

  // floor shift, subtract, saturate
  always_comb begin
    shifted = prod_r >>> FRAC_BITS;
    diff    = 64'($signed(rd_a_r)) - shifted;
    upd_sat = 1'b1;
    if (diff > 64'sd2147483647) begin
      upd = 32'h7fffffff;
    end else if (diff < -64'sd2147483648) begin
      upd = 32'h80000000;
    end else begin
      upd     = diff[31:0];
      upd_sat = 1'b0;
    end
  end

  // work memory: two registered reads, one write
  logic [31:0] wdata;

  always_comb begin
    case (cmd.wr_sel)
      WS_STORE: wdata = store_q_r;
      WS_A:     wdata = rd_a_r;
      WS_B:     wdata = rd_b_r;
      WS_UPD:   wdata = upd;
      default:  wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      work_mem[addr_w] <= wdata;
    end
    if (cmd.rd_en) begin
      rd_a_r <= work_mem[addr_a];
      rd_b_r <= work_mem[addr_b];
    end
  end

  // saturation flag
  logic sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r <= 1'b0;
    end else if (cmd.sat_clr) begin
      sat_r <= 1'b0;
    end else if ((busy_r && (cnt_r == NW'(1)) && f_sat) ||
                 (cmd.wr_en && (cmd.wr_sel == WS_UPD) && upd_sat)) begin
      sat_r <= 1'b1;
    end
  end

  assign sts.over_tol = {1'b0, abs32(rd_a_r)} > {2'b00, tol};
  assign sts.a_zero   = (rd_a_r == 32'd0);
  assign sts.div_busy = busy_r;
  assign sts.sat      = sat_r;

endmodule

// ===== rtl/mrg_ctrl.sv =====
module mrg_ctrl #(
  parameter int MAX_ROWS = mrg_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = mrg_pkg::MAX_COLS_DEF,
  parameter int RW = $clog2(MAX_ROWS + 1),
  parameter int CW = $clog2(MAX_COLS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last_elem,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [3:0]    rank,
  output logic          saturated,
  input  logic [3:0]    rows_used,
  input  logic [3:0]    cols_used,
  input  mrg_pkg::sts_t sts,
  output mrg_pkg::cmd_t cmd,
  output logic [RW-1:0] a_row,
  output logic [CW-1:0] a_col,
  output logic [RW-1:0] b_row,
  output logic [CW-1:0] b_col,
  output logic [RW-1:0] w_row,
  output logic [CW-1:0] w_col
);
  import mrg_pkg::*;

  state_t state_r, state_nxt;
  logic [RW-1:0] i_r, i_nxt, r_r, r_nxt, piv_r, piv_nxt;
  logic [CW-1:0] j_r, j_nxt, c_r, c_nxt;
  logic [RW-1:0] m;
  logic [CW-1:0] n;
  logic          start;
  logic          out_valid_r;
  logic [3:0]    rank_r;
  logic          sat_r;

  // clamp sizes to the array
  assign m = (32'(rows_used) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(rows_used);
  assign n = (32'(cols_used) > MAX_COLS) ? CW'(MAX_COLS) : CW'(cols_used);

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || !in_last_elem);
  assign start    = in_valid && in_ready && in_last_elem;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (start) state_nxt = S_COPY_RD;
      S_COPY_RD:  state_nxt = S_COPY_WR;
      S_COPY_WR: begin
        if ((j_r == CW'(MAX_COLS - 1)) && (i_r == RW'(MAX_ROWS - 1))) state_nxt = S_COL;
        else state_nxt = S_COPY_RD;
      end
      S_COL: begin
        if ((c_r >= n) || (r_r >= m)) state_nxt = S_FIN;
        else state_nxt = S_SRCH_RD;
      end
      S_SRCH_RD: begin
        if (i_r >= m) state_nxt = S_COL;
        else state_nxt = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        if (!sts.over_tol) state_nxt = S_SRCH_RD;
        else if (i_r != r_r) state_nxt = S_SW_RD;
        else state_nxt = S_EL_ROW;
      end
      S_SW_RD:    state_nxt = S_SW_WA;
      S_SW_WA:    state_nxt = S_SW_WB;
      S_SW_WB: begin
        if (j_r + CW'(1) >= n) state_nxt = S_EL_ROW;
        else state_nxt = S_SW_RD;
      end
      S_EL_ROW: begin
        if (i_r >= m) state_nxt = S_COL;
        else if (i_r != r_r) state_nxt = S_EL_CHK;
      end
      S_EL_CHK: begin
        if (sts.a_zero) state_nxt = S_EL_ROW;
        else state_nxt = S_EL_DIV;
      end
      S_EL_DIV:   if (!sts.div_busy) state_nxt = S_EL_RD;
      S_EL_RD: begin
        if (j_r >= n) state_nxt = S_EL_ROW;
        else state_nxt = S_EL_MUL;
      end
      S_EL_MUL:   state_nxt = S_EL_WR;
      S_EL_WR:    state_nxt = S_EL_RD;
      S_FIN:      state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // loop counters
  always_comb begin
    i_nxt   = i_r;
    j_nxt   = j_r;
    r_nxt   = r_r;
    c_nxt   = c_r;
    piv_nxt = piv_r;
    case (state_r)
      S_IDLE: begin
        i_nxt = '0;
        j_nxt = '0;
      end
      S_COPY_WR: begin
        if (j_r == CW'(MAX_COLS - 1)) begin
          j_nxt = '0;
          i_nxt = i_r + RW'(1);
        end else begin
          j_nxt = j_r + CW'(1);
        end
        r_nxt = '0;
        c_nxt = '0;
      end
      S_COL:      i_nxt = r_r;
      S_SRCH_RD:  if (i_r >= m) c_nxt = c_r + CW'(1);
      S_SRCH_CHK: begin
        if (!sts.over_tol) begin
          i_nxt = i_r + RW'(1);
        end else begin
          piv_nxt = i_r;
          j_nxt   = '0;
          if (i_r == r_r) i_nxt = '0;
        end
      end
      S_SW_WB: begin
        j_nxt = j_r + CW'(1);
        i_nxt = '0;
      end
      S_EL_ROW: begin
        if (i_r >= m) begin
          r_nxt = r_r + RW'(1);
          c_nxt = c_r + CW'(1);
        end else if (i_r == r_r) begin
          i_nxt = i_r + RW'(1);
        end
      end
      S_EL_CHK:   if (sts.a_zero) i_nxt = i_r + RW'(1);
      S_EL_DIV:   j_nxt = '0;
      S_EL_RD:    if (j_r >= n) i_nxt = i_r + RW'(1);
      S_EL_WR:    j_nxt = j_r + CW'(1);
      default:    ;
    endcase
  end

  // datapath commands and addresses
  always_comb begin
    cmd.copy_rd   = 1'b0;
    cmd.rd_en     = 1'b0;
    cmd.wr_en     = 1'b0;
    cmd.wr_sel    = WS_STORE;
    cmd.div_start = 1'b0;
    cmd.mul_en    = 1'b0;
    cmd.sat_clr   = 1'b0;
    a_row = (state_r == S_SW_RD) ? r_r : i_r;
    a_col = ((state_r == S_SRCH_RD) || (state_r == S_EL_ROW)) ? c_r : j_r;
    b_row = (state_r == S_SW_RD) ? piv_r : r_r;
    b_col = (state_r == S_EL_ROW) ? c_r : j_r;
    w_row = (state_r == S_SW_WA) ? r_r : ((state_r == S_SW_WB) ? piv_r : i_r);
    w_col = j_r;
    unique case (state_r)
      S_IDLE:    cmd.sat_clr = start;
      S_COPY_RD: cmd.copy_rd = 1'b1;
      S_COPY_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WS_STORE;
      end
      S_SRCH_RD: cmd.rd_en = (i_r < m);
      S_SW_RD:   cmd.rd_en = 1'b1;
      S_SW_WA: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WS_B;
      end
      S_SW_WB: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WS_A;
      end
      S_EL_ROW:  cmd.rd_en = (i_r < m) && (i_r != r_r);
      S_EL_CHK:  cmd.div_start = !sts.a_zero;
      S_EL_RD:   cmd.rd_en = (j_r < n);
      S_EL_MUL:  cmd.mul_en = 1'b1;
      S_EL_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = (j_r == c_r) ? WS_ZERO : WS_UPD;
      end
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      r_r         <= '0;
      c_r         <= '0;
      piv_r       <= '0;
      out_valid_r <= 1'b0;
      rank_r      <= '0;
      sat_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      r_r     <= r_nxt;
      c_r     <= c_nxt;
      piv_r   <= piv_nxt;
      // result register
      if (state_r == S_FIN) begin
        out_valid_r <= 1'b1;
        rank_r      <= 4'(r_r);
        sat_r       <= sts.sat;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign rank      = rank_r;
  assign saturated = sat_r;

endmodule

// ===== rtl/matrix_rank_gauss_elim.sv =====
// loading: one element per cycle while in_ready is high, each written into the element store
// after the last element the whole store is copied to work memory, read then write per element,
// then per column a search that reads and checks each row, per pivot a row swap (read both
// rows, write each per column), and per cleared row a bit-serial divide to 32+FRAC_BITS bits,
// then read, multiply, write per column; the single write port and the divider set the pace
// reset: synchronous active low; element store is undefined until written
module matrix_rank_gauss_elim #(
  parameter int MAX_ROWS  = mrg_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS  = mrg_pkg::MAX_COLS_DEF,
  parameter int FRAC_BITS = mrg_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_row_index,
  input  logic [2:0]  in_col_index,
  input  logic [31:0] in_elem_value,
  input  logic        in_last_elem,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_matrix_rank,
  output logic        out_saturated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import mrg_pkg::*;

  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int CW = $clog2(MAX_COLS + 1);

  logic [3:0]  rows_used_r;
  logic [3:0]  cols_used_r;
  logic [30:0] tol_r;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_used_r <= 4'd8;
      cols_used_r <= 4'd8;
      tol_r       <= 31'd16;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ROWS: rows_used_r <= cfg_data[3:0];
        CFG_COLS: cols_used_r <= cfg_data[3:0];
        CFG_TOL:  tol_r       <= cfg_data[30:0];
        default:  ;
      endcase
    end
  end

  cmd_t          cmd;
  sts_t          sts;
  logic [RW-1:0] a_row, b_row, w_row;
  logic [CW-1:0] a_col, b_col, w_col;

  mrg_ctrl #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS),
    .RW(RW),
    .CW(CW)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_last_elem(in_last_elem),
    .in_ready(in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .rank(out_matrix_rank),
    .saturated(out_saturated),
    .rows_used(rows_used_r),
    .cols_used(cols_used_r),
    .sts(sts),
    .cmd(cmd),
    .a_row(a_row),
    .a_col(a_col),
    .b_row(b_row),
    .b_col(b_col),
    .w_row(w_row),
    .w_col(w_col)
  );

  mrg_dp #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS),
    .FRAC_BITS(FRAC_BITS),
    .RW(RW),
    .CW(CW)
  ) u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .load_en(in_valid && in_ready),
    .load_row(in_row_index),
    .load_col(in_col_index),
    .load_val(in_elem_value),
    .tol(tol_r),
    .cmd(cmd),
    .a_row(a_row),
    .a_col(a_col),
    .b_row(b_row),
    .b_col(b_col),
    .w_row(w_row),
    .w_col(w_col),
    .sts(sts)
  );

  // a last-element transfer makes the block busy
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last_elem) |=> !in_ready)
    else $error("input accepted right after last element");

  // a result appears only after a computation
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without computation");

  // rank never exceeds the rows taking part
  a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_matrix_rank <= rows_used_r))
    else $error("rank above row count");

endmodule

// ===== tb/matrix_rank_gauss_elim_tb.sv =====
`timescale 1ns / 100ps

module matrix_rank_gauss_elim_tb;
  import mrg_pkg::*;

  localparam int NR = MAX_ROWS_DEF;
  localparam int NC = MAX_COLS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam logic [30:0] TOL_MAX = 31'h7fffffff;
  localparam int ITEM_TARGET = 1700;

  typedef struct {
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] val;
    logic        last;
  } elem_t;

  typedef struct {
    logic [3:0] rank;
    logic       sat;
  } rank_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_row_index = '0;
  logic [2:0] in_col_index = '0;
  logic [31:0] in_elem_value = '0;
  logic in_last_elem = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [3:0] out_matrix_rank;
  logic out_saturated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // predictor state: loaded elements and register copies
  int signed elem_store [NR][NC];
  int rows_cfg = 8;
  int cols_cfg = 8;
  longint tol_cfg = 16;

  elem_t elem_q[$];
  rank_res_t rank_expect_q[$];
  elem_t cur_elem;
  int drv_gap = 0;
  int rcv_gap = 0;
  int hold_cnt = 0;
  bit hold_done = 0;
  bit quiet = 0;
  int err_count = 0;
  int items_queued = 0;
  int items_taken = 0;
  int ranks_seen = 0;
  int sat_seen = 0;
  int cfg_writes = 0;

  matrix_rank_gauss_elim dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_row_index(in_row_index), .in_col_index(in_col_index),
    .in_elem_value(in_elem_value), .in_last_elem(in_last_elem),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_matrix_rank(out_matrix_rank), .out_saturated(out_saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // clip to signed 32 bits, noting any clipping
  function automatic longint clip32(input longint v, inout bit hit);
    if (v > S32_MAX) begin
      hit = 1;
      return S32_MAX;
    end
    if (v < S32_MIN) begin
      hit = 1;
      return S32_MIN;
    end
    return v;
  endfunction

  // gauss-jordan elimination over the used sub-matrix of a copy of the element store
  function automatic void predict_rank(output logic [3:0] rank, output bit sat);
    longint w [NR][NC];
    longint mag, num, f, tmp;
    int m, n, r, piv;
    sat = 0;
    m = (rows_cfg > NR) ? NR : rows_cfg;
    n = (cols_cfg > NC) ? NC : cols_cfg;
    r = 0;
    for (int i = 0; i < NR; i++)
      for (int j = 0; j < NC; j++)
        w[i][j] = elem_store[i][j];
    for (int c = 0; c < n; c++) begin
      piv = m;
      for (int i = r; i < m; i++) begin
        mag = (w[i][c] < 0) ? -w[i][c] : w[i][c];
        if (mag > tol_cfg) begin
          piv = i;
          break;
        end
      end
      if (piv >= m) continue;
      if (piv != r) begin
        for (int j = 0; j < NC; j++) begin
          tmp = w[r][j];
          w[r][j] = w[piv][j];
          w[piv][j] = tmp;
        end
      end
      for (int i = 0; i < m; i++) begin
        if (i == r || w[i][c] == 0) continue;
        num = w[i][c] * (64'sd1 << FB);
        f = clip32(num / w[r][c], sat);
        for (int j = 0; j < n; j++) begin
          if (j == c) w[i][j] = 0;
          else w[i][j] = clip32(w[i][j] - ((f * w[r][j]) >>> FB), sat);
        end
      end
      r++;
    end
    rank = r[3:0];
  endfunction

  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, 3);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // input driver: one element per transfer, random gap after each
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      drv_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        items_taken++;
        elem_store[cur_elem.row][cur_elem.col] = $signed(cur_elem.val);
        if (cur_elem.last) begin
          rank_res_t e;
          predict_rank(e.rank, e.sat);
          rank_expect_q.push_back(e);
        end
        drv_gap = draw_wait();
      end
      if (!in_valid || in_ready) begin
        if (drv_gap == 0 && elem_q.size() > 0) begin
          cur_elem = elem_q.pop_front();
          in_row_index <= cur_elem.row;
          in_col_index <= cur_elem.col;
          in_elem_value <= cur_elem.val;
          in_last_elem <= cur_elem.last;
          in_valid <= 1'b1;
        end else begin
          if (drv_gap > 0) drv_gap--;
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off once a few ranks have come out
  always @(posedge clk) begin
    if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
    else if (!hold_done && ranks_seen == 3) begin
      hold_cnt <= 6000;
      hold_done <= 1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rcv_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        ranks_seen++;
        if (out_saturated) sat_seen++;
        if (rank_expect_q.size() == 0) begin
          report_mismatch("unexpected rank transfer", out_matrix_rank, -1);
        end else begin
          rank_res_t e;
          e = rank_expect_q.pop_front();
          if (out_matrix_rank !== e.rank)
            report_mismatch("matrix_rank", out_matrix_rank, e.rank);
          if (out_saturated !== e.sat)
            report_mismatch("saturated", out_saturated, e.sat);
        end
        rcv_gap = draw_wait();
      end else if (rcv_gap > 0) begin
        rcv_gap--;
      end
      out_ready <= (rcv_gap == 0) && (hold_cnt == 0);
    end
  end

  task automatic push_elem(input int r, input int c, input logic [31:0] v, input bit last);
    elem_t e;
    e.row = r[2:0];
    e.col = c[2:0];
    e.val = v;
    e.last = last;
    elem_q.push_back(e);
    items_queued++;
  endtask

  // every queued element transferred and every rank received
  task automatic wait_idle();
    do @(posedge clk);
    while (items_taken < items_queued || in_valid || rank_expect_q.size() > 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ROWS: rows_cfg = v[3:0];
      CFG_COLS: cols_cfg = v[3:0];
      CFG_TOL:  tol_cfg = v[30:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic set_sizes(input int r, input int c, input logic [30:0] tol);
    wait_idle();
    write_reg(CFG_ROWS, r);
    write_reg(CFG_COLS, c);
    write_reg(CFG_TOL, {1'b0, tol});
  endtask

  // element value by content style
  function automatic logic [31:0] pick_value(input int style);
    case (style)
      0: return $urandom();
      1: return ($urandom_range(0, 6) - 3) <<< FB;
      2: return $urandom_range(0, 40) - 20;
      default: return (($urandom_range(0, 8) - 4) <<< (FB - 1)) + $urandom_range(0, 3);
    endcase
  endfunction

  // full load of the used area, last element starts the computation
  task automatic load_matrix(input int style);
    int m, n, k;
    int base [4][NC];
    int coef [NR];
    m = (rows_cfg == 0 || rows_cfg > NR) ? NR : rows_cfg;
    n = (cols_cfg == 0 || cols_cfg > NC) ? NC : cols_cfg;
    k = $urandom_range(1, 4);
    for (int b = 0; b < 4; b++)
      for (int j = 0; j < NC; j++)
        base[b][j] = $urandom_range(0, 6) - 3;
    for (int i = 0; i < NR; i++) coef[i] = $urandom_range(0, 4) - 2;
    for (int i = 0; i < m; i++)
      for (int j = 0; j < n; j++) begin
        logic [31:0] v;
        if (style == 4) v = (coef[i] * base[i % k][j]) <<< FB;
        else v = pick_value(style);
        push_elem(i, j, v, (i == m - 1) && (j == n - 1));
      end
  endtask

  // stimulus
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // whole store written first, at reset sizes
    for (int i = 0; i < NR; i++)
      for (int j = 0; j < NC; j++)
        push_elem(i, j, pick_value(i % 4), (i == NR - 1) && (j == NC - 1));

    // directed: value extremes and single element updates
    push_elem(0, 0, 32'h8000_0000, 1);
    push_elem(7, 7, 32'h7fff_ffff, 1);
    push_elem(3, 4, 32'h0000_0000, 0);
    push_elem(1, 1, 32'hffff_ffff, 1);
    push_elem(5, 2, 32'h0000_0001, 0);
    push_elem(2, 6, 32'h0001_0000, 1);
    push_elem(6, 3, 32'h8000_0001, 1);
    push_elem(4, 5, 32'h0000_0010, 1);
    push_elem(4, 5, 32'h0000_0011, 1);

    // directed: size zero, oversized, tolerance extremes, single row/column
    set_sizes(0, 5, 16);
    push_elem(0, 0, 32'h0001_0000, 1);
    set_sizes(15, 15, 0);
    push_elem(2, 2, 32'h0000_0001, 1);
    set_sizes(3, 0, 16);
    push_elem(1, 1, 32'h0003_0000, 1);
    set_sizes(1, 8, TOL_MAX);
    push_elem(0, 0, 32'h7fff_ffff, 1);
    push_elem(0, 0, 32'h8000_0000, 1);
    set_sizes(8, 1, 16);
    push_elem(7, 0, 32'hfff0_0000, 1);
    set_sizes(8, 8, 16);
    load_matrix(4);

    // random part
    while (items_queued < ITEM_TARGET) begin
      int sel;
      quiet = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 5) == 0) begin
        int tsel;
        logic [30:0] tol;
        tsel = $urandom_range(0, 9);
        tol = (tsel == 0) ? 31'd0 : (tsel == 1) ? TOL_MAX :
              (tsel == 2) ? 31'($urandom()) : 31'($urandom_range(0, 4096));
        set_sizes(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8),
                  ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8),
                  tol);
      end
      sel = $urandom_range(0, 19);
      if (sel < 12) begin
        load_matrix($urandom_range(0, 4));
      end else if (sel < 17) begin
        int cnt;
        cnt = $urandom_range(1, 6);
        for (int q = 0; q < cnt; q++)
          push_elem($urandom_range(0, 7), $urandom_range(0, 7),
                    pick_value($urandom_range(0, 3)), q == cnt - 1);
      end else begin
        push_elem($urandom_range(0, 7), $urandom_range(0, 7), $urandom(), $urandom_range(0, 1));
      end
    end

    wait_idle();
    repeat (50) @(posedge clk);
    $display("run: %0d elements sent, %0d ranks checked (%0d saturated), %0d register writes",
             items_taken, ranks_seen, sat_seen, cfg_writes);
    $display("receiver held off once for 6000 cycles; %0d mismatches", err_count);
    if (err_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("timeout: %0d ranks still expected", rank_expect_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
